FILE: rtl/tscl_pkg.sv
package tscl_pkg;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_UPLOAD = 2'd1,
    OP_FRAME  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_HIT       = 4'd0,
    ST_MISS      = 4'd1,
    ST_REUSED    = 4'd2,
    ST_FREE      = 4'd3,
    ST_EVICTED   = 4'd4,
    ST_BAD_REQ   = 4'd5,
    ST_BAD_RES   = 4'd6,
    ST_BAD_SIZE  = 4'd7,
    ST_FULL      = 4'd8,
    ST_FRAME_ADV = 4'd9
  } status_t;

  typedef enum logic [1:0] {
    REG_ACTIVE_SLOTS = 2'd0,
    REG_PINNED_LEVEL = 2'd1,
    REG_ATLAS_RES    = 2'd2,
    REG_NONE         = 2'd3
  } reg_idx_t;

  localparam int LEVEL_W = 5;
  localparam int RES_W   = 13;
  localparam int TEXEL_W = 25;
  localparam int CNT_W   = 32;

  // control from the sequencer to the victim search
  typedef struct packed {
    logic start;
    logic cand_v;
  } scan_ctl_t;

  typedef struct packed {
    logic match;
    logic found;
  } scan_stat_t;

endpackage

FILE: rtl/tscl_ifs.sv
interface tscl_in_if #(parameter int KEY_BITS = 48);
  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic [KEY_BITS-1:0] tile_key;
  logic [4:0]          tile_level;
  logic                key_valid;
  logic                command_present;
  logic [12:0]         tile_resolution;
  logic [24:0]         texel_count;

  modport source (output valid, operation, tile_key, tile_level, key_valid,
                  command_present, tile_resolution, texel_count, input ready);
  modport sink (input valid, operation, tile_key, tile_level, key_valid,
                command_present, tile_resolution, texel_count, output ready);
endinterface

interface tscl_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  result_slot;
  logic        slot_valid;
  logic [3:0]  status;
  logic [8:0]  resident_count;
  logic [31:0] eviction_count;
  logic [31:0] upload_count;
  logic [31:0] failed_upload_count;

  modport source (output valid, result_slot, slot_valid, status, resident_count,
                  eviction_count, upload_count, failed_upload_count, input ready);
  modport sink (input valid, result_slot, slot_valid, status, resident_count,
                eviction_count, upload_count, failed_upload_count, output ready);
endinterface

FILE: rtl/tile_slot_cache_lru.sv
// Fully associative tile slot table with least-recently-used replacement.
// A find scans the active slots in order through the entry memory, one slot
// per cycle. An upload adds a walk over the resident bits from the roving
// cursor and, when the table is full, a second memory pass that picks the
// oldest evictable slot, then a write. A begin frame or an upload that fails
// its checks goes straight to the response. The entry memory has a single
// read port and the compare unit is shared; one request is in flight at a
// time and in_if.ready is low while it is worked on.
// Writing active_slots empties the table at once.
module tile_slot_cache_lru import tscl_pkg::*; #(
  parameter int SLOTS      = 256,
  parameter int KEY_BITS   = 48,
  parameter int FRAME_BITS = 40
) (
  input  logic              clk,
  input  logic              rst_n,
  tscl_in_if.sink           in_if,
  tscl_out_if.source        out_if,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [3:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int AW    = $clog2(SLOTS);
  localparam int NW    = AW + 1;
  localparam int WW    = KEY_BITS + LEVEL_W + FRAME_BITS;
  localparam int N_RST = (SLOTS < 256) ? SLOTS : 256;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_LOOK, S_FREE, S_EVICT, S_WRITE, S_RESP
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [NW-1:0]      n_r, n_nxt;
  logic [LEVEL_W-1:0] pinned_r, pinned_nxt;
  logic [RES_W-1:0]   atlas_r, atlas_nxt;

  // latched request
  logic [1:0]          op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [LEVEL_W-1:0]  lvl_r;
  logic                kv_r, cmd_r;
  logic [RES_W-1:0]    res_r;
  logic [TEXEL_W-1:0]  tex_r;

  // table state
  logic [SLOTS-1:0]      resident_r, resident_nxt;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic [AW-1:0]         cursor_r, cursor_nxt;
  logic [NW-1:0]         residents_r, residents_nxt;
  logic [CNT_W-1:0]      evict_cnt_r, evict_cnt_nxt;
  logic [CNT_W-1:0]      upload_cnt_r, upload_cnt_nxt;
  logic [CNT_W-1:0]      fail_cnt_r, fail_cnt_nxt;

  // scan pipeline
  logic [AW-1:0] idx_r, idx_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          pv_r, pv_nxt;
  logic [AW-1:0] pidx_r, pidx_nxt;
  logic          issue;

  // result
  logic [AW-1:0] slot_r, slot_nxt;
  logic          slotv_r, slotv_nxt;
  status_t       status_r, status_nxt;

  logic          out_v_r, out_v_nxt;
  logic [7:0]    o_slot_r, o_slot_nxt;
  logic          o_sv_r, o_sv_nxt;
  logic [3:0]    o_st_r, o_st_nxt;
  logic [8:0]    o_res_r, o_res_nxt;
  logic [CNT_W-1:0] o_ev_r, o_ev_nxt, o_up_r, o_up_nxt, o_fl_r, o_fl_nxt;

  // memory
  logic          we;
  logic [AW-1:0] waddr;
  logic [WW-1:0] wdata, rdata;

  logic [KEY_BITS-1:0]   rd_key;
  logic [LEVEL_W-1:0]    rd_level;
  logic [FRAME_BITS-1:0] rd_stamp;

  scan_ctl_t     sctl;
  scan_stat_t    sstat;
  logic [AW-1:0] victim;

  logic          cfg_wr;
  reg_idx_t      cfg_idx;
  logic [8:0]    act_v;
  logic [2*RES_W-1:0] sq;
  logic          accept;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i,
                                             input logic [NW-1:0] n);
    logic [NW-1:0] s;
    s = {1'b0, i} + NW'(1);
    wrap_inc = (s == n) ? '0 : s[AW-1:0];
  endfunction

  assign rd_key   = rdata[WW-1 -: KEY_BITS];
  assign rd_level = rdata[FRAME_BITS +: LEVEL_W];
  assign rd_stamp = rdata[FRAME_BITS-1:0];

  tscl_ram #(.WIDTH(WW), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx_r),
    .rdata (rdata)
  );

  tscl_scan #(.KEY_BITS(KEY_BITS), .FRAME_BITS(FRAME_BITS), .AW(AW)) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sctl),
    .pidx     (pidx_r),
    .rd_key   (rd_key),
    .key      (key_r),
    .rd_level (rd_level),
    .pinned   (pinned_r),
    .rd_stamp (rd_stamp),
    .frame    (frame_r),
    .stat     (sstat),
    .victim   (victim)
  );

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;
  assign act_v      = cfg_pwdata[8:0];

  always_comb begin
    case (cfg_idx)
      REG_ACTIVE_SLOTS: cfg_prdata = 32'(n_r);
      REG_PINNED_LEVEL: cfg_prdata = 32'(pinned_r);
      REG_ATLAS_RES:    cfg_prdata = 32'(atlas_r);
      default:          cfg_prdata = '0;
    endcase
  end

  assign in_if.ready = (state_r == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign sq          = res_r * res_r;
  assign issue       = (cnt_r < n_r);

  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    pinned_nxt     = pinned_r;
    atlas_nxt      = atlas_r;
    resident_nxt   = resident_r;
    frame_nxt      = frame_r;
    cursor_nxt     = cursor_r;
    residents_nxt  = residents_r;
    evict_cnt_nxt  = evict_cnt_r;
    upload_cnt_nxt = upload_cnt_r;
    fail_cnt_nxt   = fail_cnt_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    pv_nxt         = 1'b0;
    pidx_nxt       = idx_r;
    slot_nxt       = slot_r;
    slotv_nxt      = slotv_r;
    status_nxt     = status_r;
    out_v_nxt      = out_v_r;
    o_slot_nxt     = o_slot_r;
    o_sv_nxt       = o_sv_r;
    o_st_nxt       = o_st_r;
    o_res_nxt      = o_res_r;
    o_ev_nxt       = o_ev_r;
    o_up_nxt       = o_up_r;
    o_fl_nxt       = o_fl_r;
    we             = 1'b0;
    waddr          = pidx_r;
    wdata          = {rd_key, rd_level, frame_r};
    sctl.start     = 1'b0;
    sctl.cand_v    = 1'b0;

    if (out_if.ready) begin
      out_v_nxt = 1'b0;
    end

    if (cfg_wr) begin
      case (cfg_idx)
        REG_ACTIVE_SLOTS: begin
          if (act_v == '0) begin
            n_nxt = NW'(1);
          end else if (32'(act_v) > SLOTS) begin
            n_nxt = NW'(SLOTS);
          end else begin
            n_nxt = NW'(act_v);
          end
          resident_nxt  = '0;
          cursor_nxt    = '0;
          residents_nxt = '0;
        end
        REG_PINNED_LEVEL: pinned_nxt = cfg_pwdata[LEVEL_W-1:0];
        REG_ATLAS_RES:    atlas_nxt = cfg_pwdata[RES_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        slotv_nxt = 1'b0;
        idx_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_RESP;
        case (op_t'(op_r))
          OP_FIND: begin
            if (kv_r) begin
              state_nxt = S_LOOK;
            end else begin
              status_nxt = ST_MISS;
            end
          end
          OP_UPLOAD: begin
            if (!cmd_r || !kv_r) begin
              status_nxt   = ST_BAD_REQ;
              fail_cnt_nxt = fail_cnt_r + 1'b1;
            end else if (res_r != atlas_r) begin
              status_nxt   = ST_BAD_RES;
              fail_cnt_nxt = fail_cnt_r + 1'b1;
            end else if ({1'b0, tex_r} != sq) begin
              status_nxt   = ST_BAD_SIZE;
              fail_cnt_nxt = fail_cnt_r + 1'b1;
            end else begin
              state_nxt = S_LOOK;
            end
          end
          OP_FRAME: begin
            frame_nxt  = frame_r + 1'b1;
            status_nxt = ST_FRAME_ADV;
          end
          default: status_nxt = ST_BAD_REQ;
        endcase
      end
      S_LOOK: begin
        // one read issued per cycle, compared when its data returns from the memory
        pv_nxt  = issue;
        idx_nxt = issue ? wrap_inc(idx_r, n_r) : idx_r;
        cnt_nxt = cnt_r + NW'(issue);
        if (pv_r && resident_r[pidx_r] && sstat.match) begin
          we         = 1'b1;
          slot_nxt   = pidx_r;
          slotv_nxt  = 1'b1;
          pv_nxt     = 1'b0;
          state_nxt  = S_RESP;
          if (op_t'(op_r) == OP_UPLOAD) begin
            status_nxt     = ST_REUSED;
            upload_cnt_nxt = upload_cnt_r + 1'b1;
          end else begin
            status_nxt = ST_HIT;
          end
        end else if (!issue && !pv_r) begin
          if (op_t'(op_r) == OP_UPLOAD) begin
            idx_nxt   = cursor_r;
            cnt_nxt   = '0;
            state_nxt = S_FREE;
          end else begin
            status_nxt = ST_MISS;
            state_nxt  = S_RESP;
          end
        end
      end
      S_FREE: begin
        if (!issue) begin
          idx_nxt    = cursor_r;
          cnt_nxt    = '0;
          sctl.start = 1'b1;
          state_nxt  = S_EVICT;
        end else if (!resident_r[idx_r]) begin
          slot_nxt   = idx_r;
          cursor_nxt = wrap_inc(idx_r, n_r);
          status_nxt = ST_FREE;
          state_nxt  = S_WRITE;
        end else begin
          idx_nxt = wrap_inc(idx_r, n_r);
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_EVICT: begin
        sctl.cand_v = pv_r;
        pv_nxt      = issue;
        idx_nxt     = issue ? wrap_inc(idx_r, n_r) : idx_r;
        cnt_nxt     = cnt_r + NW'(issue);
        if (!issue && !pv_r) begin
          if (sstat.found) begin
            slot_nxt              = victim;
            resident_nxt[victim]  = 1'b0;
            residents_nxt         = residents_r - 1'b1;
            evict_cnt_nxt         = evict_cnt_r + 1'b1;
            cursor_nxt            = wrap_inc(victim, n_r);
            status_nxt            = ST_EVICTED;
            state_nxt             = S_WRITE;
          end else begin
            status_nxt   = ST_FULL;
            fail_cnt_nxt = fail_cnt_r + 1'b1;
            state_nxt    = S_RESP;
          end
        end
      end
      S_WRITE: begin
        we                     = 1'b1;
        waddr                  = slot_r;
        wdata                  = {key_r, lvl_r, frame_r};
        resident_nxt[slot_r]   = 1'b1;
        residents_nxt          = residents_r + 1'b1;
        upload_cnt_nxt         = upload_cnt_r + 1'b1;
        slotv_nxt              = 1'b1;
        state_nxt              = S_RESP;
      end
      S_RESP: begin
        if (!out_v_r || out_if.ready) begin
          out_v_nxt  = 1'b1;
          o_slot_nxt = slotv_r ? 8'(slot_r) : 8'd0;
          o_sv_nxt   = slotv_r;
          o_st_nxt   = status_r;
          o_res_nxt  = 9'(residents_r);
          o_ev_nxt   = evict_cnt_r;
          o_up_nxt   = upload_cnt_r;
          o_fl_nxt   = fail_cnt_r;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      n_r          <= NW'(N_RST);
      pinned_r     <= '0;
      atlas_r      <= RES_W'(256);
      resident_r   <= '0;
      frame_r      <= '0;
      cursor_r     <= '0;
      residents_r  <= '0;
      evict_cnt_r  <= '0;
      upload_cnt_r <= '0;
      fail_cnt_r   <= '0;
      pv_r         <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      n_r          <= n_nxt;
      pinned_r     <= pinned_nxt;
      atlas_r      <= atlas_nxt;
      resident_r   <= resident_nxt;
      frame_r      <= frame_nxt;
      cursor_r     <= cursor_nxt;
      residents_r  <= residents_nxt;
      evict_cnt_r  <= evict_cnt_nxt;
      upload_cnt_r <= upload_cnt_nxt;
      fail_cnt_r   <= fail_cnt_nxt;
      pv_r         <= pv_nxt;
      out_v_r      <= out_v_nxt;
    end
    if (accept) begin
      op_r  <= in_if.operation;
      key_r <= in_if.tile_key;
      lvl_r <= in_if.tile_level;
      kv_r  <= in_if.key_valid;
      cmd_r <= in_if.command_present;
      res_r <= in_if.tile_resolution;
      tex_r <= in_if.texel_count;
    end
    idx_r    <= idx_nxt;
    cnt_r    <= cnt_nxt;
    pidx_r   <= pidx_nxt;
    slot_r   <= slot_nxt;
    slotv_r  <= slotv_nxt;
    status_r <= status_nxt;
    o_slot_r <= o_slot_nxt;
    o_sv_r   <= o_sv_nxt;
    o_st_r   <= o_st_nxt;
    o_res_r  <= o_res_nxt;
    o_ev_r   <= o_ev_nxt;
    o_up_r   <= o_up_nxt;
    o_fl_r   <= o_fl_nxt;
  end

  assign out_if.valid               = out_v_r;
  assign out_if.result_slot         = o_slot_r;
  assign out_if.slot_valid          = o_sv_r;
  assign out_if.status              = o_st_r;
  assign out_if.resident_count      = o_res_r;
  assign out_if.eviction_count      = o_ev_r;
  assign out_if.upload_count        = o_up_r;
  assign out_if.failed_upload_count = o_fl_r;

`ifndef SYNTHESIS
  a_residents_bound: assert property (@(posedge clk) disable iff (!rst_n)
    residents_r <= n_r) else $error("resident count above active slots");

  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cursor_r} < n_r) else $error("scan cursor outside active window");

  a_slot_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.slot_valid |->
      (out_if.status == ST_HIT) || (out_if.status == ST_REUSED) ||
      (out_if.status == ST_FREE) || (out_if.status == ST_EVICTED))
    else $error("slot given with a failing status");

  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVICT |-> residents_r == n_r)
    else $error("eviction search with a free slot present");
`endif

endmodule

FILE: rtl/tscl_ram.sv
module tscl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/tscl_scan.sv
module tscl_scan import tscl_pkg::*; #(
  parameter int KEY_BITS   = 48,
  parameter int FRAME_BITS = 40,
  parameter int AW         = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  scan_ctl_t             ctl,
  input  logic [AW-1:0]         pidx,
  input  logic [KEY_BITS-1:0]   rd_key,
  input  logic [KEY_BITS-1:0]   key,
  input  logic [LEVEL_W-1:0]    rd_level,
  input  logic [LEVEL_W-1:0]    pinned,
  input  logic [FRAME_BITS-1:0] rd_stamp,
  input  logic [FRAME_BITS-1:0] frame,
  output scan_stat_t            stat,
  output logic [AW-1:0]         victim
);

  logic                  found_r, found_nxt;
  logic [FRAME_BITS-1:0] oldest_r, oldest_nxt;
  logic [AW-1:0]         victim_r, victim_nxt;
  logic                  take;

  // strict less keeps the first oldest entry in scan order
  assign take = ctl.cand_v && (rd_level > pinned) && (rd_stamp < frame) &&
                (!found_r || (rd_stamp < oldest_r));

  always_comb begin
    found_nxt  = found_r;
    oldest_nxt = oldest_r;
    victim_nxt = victim_r;
    if (ctl.start) begin
      found_nxt = 1'b0;
    end else if (take) begin
      found_nxt  = 1'b1;
      oldest_nxt = rd_stamp;
      victim_nxt = pidx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
    oldest_r <= oldest_nxt;
    victim_r <= victim_nxt;
  end

  assign stat.match = (rd_key == key);
  assign stat.found = found_r;
  assign victim     = victim_r;

endmodule

FILE: tb/sv/tb.sv
module tb;
  import tscl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    op_t         op;
    logic [47:0] key;
    logic [4:0]  level;
    logic        key_valid;
    logic        cmd;
    logic [12:0] res;
    logic [24:0] texels;
  } tile_req_t;

  typedef struct packed {
    logic [7:0]  slot;
    logic        slot_valid;
    status_t     status;
    logic [8:0]  residents;
    logic [31:0] evictions;
    logic [31:0] uploads;
    logic [31:0] failures;
  } slot_result_t;

  class slot_table_sb;
    logic [47:0]  ekey[256];
    logic [4:0]   elevel[256];
    bit           eres[256];
    logic [39:0]  estamp[256];
    logic [39:0]  frame;
    int           cursor, residents, nslots;
    logic [4:0]   pinned;
    logic [12:0]  atlas_res;
    logic [31:0]  evictions, uploads, failures;
    slot_result_t expected_q[$];
    int           mismatches;

    function new();
      nslots = 256;
      pinned = 0;
      atlas_res = 256;
      frame = 0;
      evictions = 0;
      uploads = 0;
      failures = 0;
      mismatches = 0;
      clear_table();
    endfunction

    function void clear_table();
      for (int i = 0; i < 256; i++) begin
        eres[i] = 0;
        estamp[i] = 0;
      end
      cursor = 0;
      residents = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] val);
      int v;
      case (idx)
        REG_ACTIVE_SLOTS: begin
          v = val[8:0];
          if (v < 1) v = 1;
          if (v > 256) v = 256;
          nslots = v;
          clear_table();
        end
        REG_PINNED_LEVEL: pinned = val[4:0];
        REG_ATLAS_RES: atlas_res = val[12:0];
        default: ;
      endcase
    endfunction

    function int find_slot(logic [47:0] k);
      for (int i = 0; i < nslots; i++)
        if (eres[i] && ekey[i] == k) return i;
      return -1;
    endfunction

    // first free slot from the cursor, else the oldest evictable one
    function int take_slot(output bit evicted);
      int idx, victim;
      logic [63:0] oldest;
      evicted = 0;
      victim = nslots;
      oldest = '1;
      for (int i = 0; i < nslots; i++) begin
        idx = (cursor + i) % nslots;
        if (!eres[idx]) begin
          cursor = (idx + 1) % nslots;
          return idx;
        end
      end
      for (int i = 0; i < nslots; i++) begin
        idx = (cursor + i) % nslots;
        if (elevel[idx] <= pinned) continue;
        if (estamp[idx] >= frame) continue;
        if ({24'd0, estamp[idx]} < oldest) begin
          oldest = {24'd0, estamp[idx]};
          victim = idx;
        end
      end
      if (victim == nslots) return -1;
      eres[victim] = 0;
      evictions++;
      residents--;
      cursor = (victim + 1) % nslots;
      evicted = 1;
      return victim;
    endfunction

    function void note_request(tile_req_t r);
      slot_result_t e;
      int s;
      bit ev;
      e = '0;
      s = -1;
      case (r.op)
        OP_FIND: begin
          s = r.key_valid ? find_slot(r.key) : -1;
          if (s >= 0) begin
            estamp[s] = frame;
            e.status = ST_HIT;
          end else begin
            e.status = ST_MISS;
          end
        end
        OP_UPLOAD: begin
          if (!r.cmd || !r.key_valid) begin
            e.status = ST_BAD_REQ;
            failures++;
          end else if (r.res != atlas_res) begin
            e.status = ST_BAD_RES;
            failures++;
          end else if (64'(r.texels) != 64'(r.res) * 64'(r.res)) begin
            e.status = ST_BAD_SIZE;
            failures++;
          end else begin
            s = find_slot(r.key);
            if (s >= 0) begin
              e.status = ST_REUSED;
            end else begin
              s = take_slot(ev);
              if (s >= 0) begin
                ekey[s] = r.key;
                elevel[s] = r.level;
                eres[s] = 1;
                residents++;
                e.status = ev ? ST_EVICTED : ST_FREE;
              end else begin
                e.status = ST_FULL;
              end
            end
            if (s >= 0) begin
              estamp[s] = frame;
              uploads++;
            end else begin
              failures++;
            end
          end
        end
        OP_FRAME: begin
          frame = frame + 1;
          e.status = ST_FRAME_ADV;
        end
        default: e.status = ST_BAD_REQ;
      endcase
      if (s >= 0) begin
        e.slot = s[7:0];
        e.slot_valid = 1;
      end
      e.residents = residents[8:0];
      e.evictions = evictions;
      e.uploads = uploads;
      e.failures = failures;
      expected_q.push_back(e);
    endfunction

    function void check_result(slot_result_t a);
      slot_result_t e;
      bit bad;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", a);
        return;
      end
      e = expected_q.pop_front();
      bad = (a.slot !== e.slot) || (a.slot_valid !== e.slot_valid) ||
            (a.status !== e.status) || (a.residents !== e.residents) ||
            (a.evictions !== e.evictions) || (a.uploads !== e.uploads) ||
            (a.failures !== e.failures);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: expected %p actual %p", e, a);
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;

  tscl_in_if #(.KEY_BITS(48)) in_if ();
  tscl_out_if out_if ();

  tile_slot_cache_lru dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  slot_table_sb sb = new();
  logic [47:0] key_pool[64];
  int          burst_left = 0;
  int          cycles = 0;
  int          stall_mode = 0;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    rst_n = 0;
    in_if.valid = 0;
    in_if.operation = OP_FIND;
    in_if.tile_key = '0;
    in_if.tile_level = '0;
    in_if.key_valid = 0;
    in_if.command_present = 0;
    in_if.tile_resolution = '0;
    in_if.texel_count = '0;
    out_if.ready = 0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 8000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: check, then pick the next ready value
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result('{out_if.result_slot, out_if.slot_valid, status_t'(out_if.status),
                        out_if.resident_count, out_if.eviction_count,
                        out_if.upload_count, out_if.failed_upload_count});
    if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= ($urandom_range(0, 3) != 0);
      default: out_if.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_req(tile_req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.operation <= r.op;
    in_if.tile_key <= r.key;
    in_if.tile_level <= r.level;
    in_if.key_valid <= r.key_valid;
    in_if.command_present <= r.cmd;
    in_if.tile_resolution <= r.res;
    in_if.texel_count <= r.texels;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(r);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 4'(idx) << 2;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  function automatic tile_req_t good_upload(logic [47:0] k, logic [4:0] lvl);
    tile_req_t r;
    r = '{OP_UPLOAD, k, lvl, 1'b1, 1'b1, sb.atlas_res, 25'(sb.atlas_res * sb.atlas_res)};
    return r;
  endfunction

  function automatic tile_req_t random_req();
    tile_req_t r;
    int pick, npool;
    npool = 2 * sb.nslots + 2;
    if (npool > 64) npool = 64;
    r = good_upload(key_pool[$urandom_range(0, npool - 1)], 5'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      r.op = OP_FIND;
    end else if (pick < 70) begin
      r.op = OP_UPLOAD;
    end else if (pick < 82) begin
      r.op = OP_FRAME;
    end else if (pick < 88) begin
      // near miss on the size check
      r.texels = r.texels + 25'($urandom_range(1, 2));
    end else begin
      r = '{op_t'($urandom_range(0, 3)), {$urandom, $urandom}, 5'($urandom),
            1'($urandom), 1'($urandom), 13'($urandom), 25'($urandom)};
      if ($urandom_range(0, 1)) r.res = sb.atlas_res;
    end
    return r;
  endfunction

  task automatic run_phase(int slots, int pin, int res, int items);
    write_reg(REG_ACTIVE_SLOTS, slots);
    write_reg(REG_PINNED_LEVEL, pin);
    write_reg(REG_ATLAS_RES, res);
    repeat (items) send_req(random_req());
  endtask

  initial begin
    tile_req_t r;
    for (int i = 0; i < 64; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests at the reset settings
    send_req('{OP_FIND, 48'h0, 5'd0, 1'b1, 1'b0, 13'd0, 25'd0});
    r = good_upload(48'h0, 5'd0);
    r.cmd = 0;
    send_req(r);
    r = good_upload(48'h0, 5'd0);
    r.key_valid = 0;
    send_req(r);
    r = good_upload(48'h0, 5'd0);
    r.res = 13'd255;
    send_req(r);
    r.res = 13'd0;
    send_req(r);
    r.res = 13'h1FFF;
    send_req(r);
    r = good_upload(48'h0, 5'd0);
    r.texels = 25'd65535;
    send_req(r);
    r.texels = 25'h1FFFFFF;
    send_req(r);
    send_req(good_upload(48'h0, 5'd0));
    send_req(good_upload('1, 5'd31));
    send_req(good_upload('1, 5'd31));
    send_req('{OP_FIND, 48'hFFFF_FFFF_FFFF, 5'd0, 1'b1, 1'b0, 13'd0, 25'd0});
    send_req('{OP_FIND, 48'hFFFF_FFFF_FFFF, 5'd0, 1'b0, 1'b0, 13'd0, 25'd0});
    send_req('{OP_NONE, '1, '1, 1'b1, 1'b1, 13'h1FFF, 25'h1FFFFFF});
    send_req('{OP_FRAME, 48'h0, 5'd0, 1'b0, 1'b0, 13'd0, 25'd0});
    send_req('{OP_FIND, 48'h0, 5'd0, 1'b1, 1'b0, 13'd0, 25'd0});

    run_phase(0, 0, 1, 150);
    run_phase(4, 3, 16, 400);
    run_phase(8, 0, 4096, 400);
    run_phase(3, 31, 2, 150);
    run_phase(16, 10, 64, 500);
    run_phase(511, 0, 8, 250);

    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
